/* design/scta_pkg.sv */
package scta_pkg;

   // Scancode set 1 codes of interest.
   localparam logic [7:0] SC_RELEASE   = 8'h80;
   localparam logic [7:0] SC_CODE_MASK = 8'h7F;
   localparam logic [7:0] SC_LSHIFT    = 8'h2A;
   localparam logic [7:0] SC_RSHIFT    = 8'h36;
   localparam logic [7:0] SC_CAPS      = 8'h3A;

   // Make codes at or above this value have no table entry.
   localparam logic [7:0] TABLE_LEN    = 8'd58;

   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] scan_byte;
   } req_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       char_stored;
      logic       char_dropped;
      logic       shift_active;
      logic       caps_active;
      logic [7:0] fill_count;
   } rsp_type;

   // Decoded meaning of one scancode byte.
   typedef struct packed {
      logic       shift_make;
      logic       shift_break;
      logic       caps_make;
      logic       has_char;
      logic [6:0] char_code;
   } key_event_type;

   function automatic logic [6:0] plain_char(input logic [5:0] idx);
      logic [6:0] c;
      unique case (idx)
         6'd1:  c = 7'h1B;
         6'd2:  c = 7'h31;
         6'd3:  c = 7'h32;
         6'd4:  c = 7'h33;
         6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;
         6'd7:  c = 7'h36;
         6'd8:  c = 7'h37;
         6'd9:  c = 7'h38;
         6'd10: c = 7'h39;
         6'd11: c = 7'h30;
         6'd12: c = 7'h2D;
         6'd13: c = 7'h3D;
         6'd14: c = 7'h08;
         6'd15: c = 7'h09;
         6'd16: c = 7'h71;
         6'd17: c = 7'h77;
         6'd18: c = 7'h65;
         6'd19: c = 7'h72;
         6'd20: c = 7'h74;
         6'd21: c = 7'h79;
         6'd22: c = 7'h75;
         6'd23: c = 7'h69;
         6'd24: c = 7'h6F;
         6'd25: c = 7'h70;
         6'd26: c = 7'h5B;
         6'd27: c = 7'h5D;
         6'd28: c = 7'h0A;
         6'd30: c = 7'h61;
         6'd31: c = 7'h73;
         6'd32: c = 7'h64;
         6'd33: c = 7'h66;
         6'd34: c = 7'h67;
         6'd35: c = 7'h68;
         6'd36: c = 7'h6A;
         6'd37: c = 7'h6B;
         6'd38: c = 7'h6C;
         6'd39: c = 7'h3B;
         6'd40: c = 7'h27;
         6'd41: c = 7'h60;
         6'd43: c = 7'h5C;
         6'd44: c = 7'h7A;
         6'd45: c = 7'h78;
         6'd46: c = 7'h63;
         6'd47: c = 7'h76;
         6'd48: c = 7'h62;
         6'd49: c = 7'h6E;
         6'd50: c = 7'h6D;
         6'd51: c = 7'h2C;
         6'd52: c = 7'h2E;
         6'd53: c = 7'h2F;
         6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] upper_char(input logic [5:0] idx);
      logic [6:0] c;
      unique case (idx)
         6'd1:  c = 7'h1B;
         6'd2:  c = 7'h21;
         6'd3:  c = 7'h40;
         6'd4:  c = 7'h23;
         6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;
         6'd7:  c = 7'h5E;
         6'd8:  c = 7'h26;
         6'd9:  c = 7'h2A;
         6'd10: c = 7'h28;
         6'd11: c = 7'h29;
         6'd12: c = 7'h5F;
         6'd13: c = 7'h2B;
         6'd14: c = 7'h08;
         6'd15: c = 7'h09;
         6'd16: c = 7'h51;
         6'd17: c = 7'h57;
         6'd18: c = 7'h45;
         6'd19: c = 7'h52;
         6'd20: c = 7'h54;
         6'd21: c = 7'h59;
         6'd22: c = 7'h55;
         6'd23: c = 7'h49;
         6'd24: c = 7'h4F;
         6'd25: c = 7'h50;
         6'd26: c = 7'h7B;
         6'd27: c = 7'h7D;
         6'd28: c = 7'h0A;
         6'd30: c = 7'h41;
         6'd31: c = 7'h53;
         6'd32: c = 7'h44;
         6'd33: c = 7'h46;
         6'd34: c = 7'h47;
         6'd35: c = 7'h48;
         6'd36: c = 7'h4A;
         6'd37: c = 7'h4B;
         6'd38: c = 7'h4C;
         6'd39: c = 7'h3A;
         6'd40: c = 7'h22;
         6'd41: c = 7'h7E;
         6'd43: c = 7'h7C;
         6'd44: c = 7'h5A;
         6'd45: c = 7'h58;
         6'd46: c = 7'h43;
         6'd47: c = 7'h56;
         6'd48: c = 7'h42;
         6'd49: c = 7'h4E;
         6'd50: c = 7'h4D;
         6'd51: c = 7'h3C;
         6'd52: c = 7'h3E;
         6'd53: c = 7'h3F;
         6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

/* design/scta_ram.sv */
module scta_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [6:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [6:0]    rd_data
);

   logic [6:0] mem [DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled result keeps its character.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/scta_translate.sv */
module scta_translate (
   input  logic                   [7:0] scan_byte,
   input  logic                         shift,
   input  logic                         caps,
   output scta_pkg::key_event_type      key_event
);

   import scta_pkg::*;

   logic [7:0] key;
   logic       release_code;
   logic       shift_code;
   logic       in_table;
   logic [6:0] lookup;

   always_comb begin
      release_code = (scan_byte & SC_RELEASE) != 8'h00;
      key          = scan_byte & SC_CODE_MASK;
      shift_code   = (key == SC_LSHIFT) || (key == SC_RSHIFT);
      in_table     = scan_byte < TABLE_LEN;
      lookup       = (shift || caps) ? upper_char(scan_byte[5:0])
                                     : plain_char(scan_byte[5:0]);

      key_event.shift_break = release_code && shift_code;
      key_event.shift_make  = !release_code && shift_code;
      key_event.caps_make   = scan_byte == SC_CAPS;
      key_event.char_code   = lookup;
      // Shift codes lie inside the table but hold zero there; caps lock lies just past it.
      key_event.has_char    = in_table && !shift_code && (scan_byte != SC_CAPS) &&
                              (lookup != 7'h00);
   end

endmodule

/* design/scancode_to_ascii_fifo_core.sv */
// Channel   Direction  Payload              Transfer when
// req_      in         cmd, scan_byte       req_valid && !req_stall
// rsp_      out        char_valid .. count  rsp_valid && !rsp_stall
//
// One item is taken per cycle while req_stall is low; its result passes
// through stage one, where the character memory read data arrives, and
// then through the output register behind it.
// Reset clears the pointers, the fill count, both key flags and the valid
// bits of the two pipeline stages; the character memory is not cleared.
// A result waiting in the output register does not stop the next transfer;
// req_stall rises only when both stages are full and rsp_stall is high.
module scancode_to_ascii_fifo_core #(
   parameter int BUF_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  scta_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scta_pkg::rsp_type rsp_data
);

   import scta_pkg::*;

   // Pointer width and count width. The count keeps at least eight bits so
   // that the saturation to the eight-bit fill field is a plain compare.
   localparam int PW = $clog2(BUF_DEPTH);
   localparam int CW = (PW > 8) ? PW : 8;

   // Ring state. The ring holds at most BUF_DEPTH-1 characters.
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          shift_ff,  shift_in;
   logic          caps_ff,   caps_in;

   // Stage one waits for the memory read data; the output stage feeds rsp_.
   logic    s1_valid_ff,  s1_valid_in;
   rsp_type s1_data_ff,   s1_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;

   logic          req_accept;
   logic          out_load;
   logic          s1_free;
   logic          empty;
   logic          full;
   logic          mem_wr_en;
   logic          mem_rd_en;
   logic [6:0]    mem_rd_data;
   key_event_type key_event;

   scta_translate u_translate (
      .scan_byte (req_data.scan_byte),
      .shift     (shift_ff),
      .caps      (caps_ff),
      .key_event (key_event)
   );

   // A read and a write never come from the same item, and a write commits
   // at the edge before any later read is issued, so no forwarding is needed.
   scta_ram #(
      .DEPTH (BUF_DEPTH),
      .AW    (PW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (key_event.char_code),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   // Pipeline flow control.
   always_comb begin
      out_load   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
      s1_free    = !s1_valid_ff || out_load;
      req_stall  = !s1_free;
      req_accept = req_valid && s1_free;
   end

   // Item processing against the current ring state.
   always_comb begin
      empty     = count_ff == '0;
      full      = count_ff == CW'(BUF_DEPTH - 1);
      mem_rd_en = req_accept && (req_data.cmd == CMD_READ) && !empty;
      mem_wr_en = req_accept && (req_data.cmd == CMD_SCAN) && key_event.has_char && !full;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      caps_in   = caps_ff;

      if (mem_rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(BUF_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
      if (mem_wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(BUF_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (req_accept && (req_data.cmd == CMD_SCAN)) begin
         if (key_event.shift_make) begin
            shift_in = 1'b1;
         end else if (key_event.shift_break) begin
            shift_in = 1'b0;
         end
         if (key_event.caps_make) begin
            caps_in = !caps_ff;
         end
      end

      // The character itself is filled in from the memory in the next stage.
      s1_data_in.char_valid   = mem_rd_en;
      s1_data_in.char_code    = 7'h00;
      s1_data_in.char_stored  = mem_wr_en;
      s1_data_in.char_dropped = req_accept && (req_data.cmd == CMD_SCAN) &&
                                key_event.has_char && full;
      s1_data_in.shift_active = shift_in;
      s1_data_in.caps_active  = caps_in;
      s1_data_in.fill_count   = (count_in > CW'(255)) ? 8'hFF : count_in[7:0];

      s1_valid_in = req_accept || (s1_valid_ff && !out_load);

      out_data_in = s1_data_ff;
      if (s1_data_ff.char_valid) begin
         out_data_in.char_code = mem_rd_data;
      end
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on a transfer into their stage.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= s1_data_in;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // The ring never holds more than BUF_DEPTH-1 characters.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUF_DEPTH - 1))
      else $error("ring count exceeds capacity");

   // The pointer distance always matches the count.
   assert property (@(posedge clock) disable iff (reset)
      ((wr_ptr_ff >= rd_ptr_ff) ?
         ({1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff}) :
         ({1'b0, wr_ptr_ff} + (PW + 1)'(BUF_DEPTH) - {1'b0, rd_ptr_ff}))
      == (PW + 1)'(count_ff))
      else $error("pointer distance disagrees with count");

   // A read of a non-empty ring yields a character in the next stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.cmd == CMD_READ) && !empty)
      |=> (s1_valid_ff && s1_data_ff.char_valid))
      else $error("read of non-empty ring lost its character");

   // A character is either stored or dropped, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.char_stored && rsp_data.char_dropped))
      else $error("character both stored and dropped");

   // While the output stalls, stage one never advances.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !out_load)
      else $error("output register overwritten while stalled");
`endif

endmodule

/* sim/scancode_to_ascii_fifo_core_tb.sv */
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_core_tb;
   import scta_pkg::*;

   // The ring has BUF_DEPTH slots and holds one character less than that.
   localparam int BUF_DEPTH   = 256;
   // The limit lies several times above what the slowest correct run needs,
   // even with long gaps and long stalls on every item.
   localparam int CYCLE_LIMIT = 600000;

   // Keeps its own copy of the key flags and the character ring. Each
   // accepted request is turned into the response it must produce, and
   // each response that leaves the block is checked against the oldest one.
   class char_ring_model;
      logic [6:0] plain_keys [TABLE_LEN];
      logic [6:0] upper_keys [TABLE_LEN];
      logic [6:0] ring [BUF_DEPTH];
      int         wr_ptr;
      int         rd_ptr;
      bit         shift_on;
      bit         caps_on;
      rsp_type    pending_rsp [$];
      int         errors;

      function new();
         // Set 1 layout, indexed by make code.
         plain_keys = '{
            7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
            7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
            7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
            7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
            7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20};
         upper_keys = '{
            7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
            7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
            7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
            7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
            7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20};
         wr_ptr   = 0;
         rd_ptr   = 0;
         shift_on = 1'b0;
         caps_on  = 1'b0;
         errors   = 0;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function void take_item(req_type item);
         rsp_type    rsp;
         logic [6:0] ch;
         int         held;
         rsp = '0;
         if (item.cmd == CMD_READ) begin
            if (wr_ptr != rd_ptr) begin
               rsp.char_valid = 1'b1;
               rsp.char_code  = ring[rd_ptr];
               rd_ptr = (rd_ptr + 1) % BUF_DEPTH;
            end
         end else if ((item.scan_byte & SC_RELEASE) != 0) begin
            // Only a shift release matters; every other break code is dropped.
            if ((item.scan_byte & SC_CODE_MASK) == SC_LSHIFT ||
                (item.scan_byte & SC_CODE_MASK) == SC_RSHIFT) begin
               shift_on = 1'b0;
            end
         end else if (item.scan_byte == SC_LSHIFT || item.scan_byte == SC_RSHIFT) begin
            shift_on = 1'b1;
         end else if (item.scan_byte == SC_CAPS) begin
            caps_on = !caps_on;
         end else if (item.scan_byte < TABLE_LEN) begin
            ch = (shift_on || caps_on) ? upper_keys[item.scan_byte]
                                       : plain_keys[item.scan_byte];
            if (ch != 7'h00) begin
               if ((wr_ptr + 1) % BUF_DEPTH != rd_ptr) begin
                  ring[wr_ptr]    = ch;
                  wr_ptr          = (wr_ptr + 1) % BUF_DEPTH;
                  rsp.char_stored = 1'b1;
               end else begin
                  rsp.char_dropped = 1'b1;
               end
            end
         end
         held = (wr_ptr - rd_ptr + BUF_DEPTH) % BUF_DEPTH;
         rsp.shift_active = shift_on;
         rsp.caps_active  = caps_on;
         rsp.fill_count   = (held > 255) ? 8'd255 : 8'(held);
         pending_rsp.push_back(rsp);
      endfunction

      function string show(rsp_type r);
         return $sformatf("valid=%0b code=%02h stored=%0b dropped=%0b shift=%0b caps=%0b fill=%0d",
                          r.char_valid, r.char_code, r.char_stored, r.char_dropped,
                          r.shift_active, r.caps_active, r.fill_count);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: response with none outstanding: %s", show(got));
            return;
         end
         want = pending_rsp.pop_front();
         if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
             got.char_stored !== want.char_stored || got.char_dropped !== want.char_dropped ||
             got.shift_active !== want.shift_active || got.caps_active !== want.caps_active ||
             got.fill_count !== want.fill_count) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: response differs at %0t", $realtime);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   // All inputs start at known values; reset is high from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   char_ring_model ring_model;
   logic [7:0]     last_key   = 8'h10;
   int             quiet_left = 0;
   int             cycles;

   scancode_to_ascii_fifo_core #(
      .BUF_DEPTH(BUF_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels are watched at the rising edge, where a transfer takes
   // place. The request is modeled first, although its response must still
   // pass through stage one and the output register.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) ring_model.take_item(req_data);
      if (!reset && rsp_valid && !rsp_stall) ring_model.check_result(rsp_data);
   end

   // The receiver alternates between free stretches and stalls. Now and
   // then a stall is long, and now and then the free stretch is long enough
   // to let a whole burst through.
   initial begin
      int free_len;
      int hold_len;
      forever begin
         free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (free_len) @(negedge clock);
         hold_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
         rsp_stall <= 1'b1;
         repeat (hold_len) @(negedge clock);
      end
   end

   // Idle cycles ahead of the next request. Quiet stretches send back to back.
   function automatic int pick_gap();
      int roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll == 0) quiet_left = $urandom_range(20, 60);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Mostly plausible typing: make codes of table keys, releases of the
   // last key pressed, shift presses and releases, caps lock, and a share
   // of arbitrary bytes.
   function automatic logic [7:0] pick_scan();
      int         roll;
      logic [7:0] code;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         code     = 8'($urandom_range(1, 57));
         last_key = code;
      end else if (roll < 68) begin
         code = last_key | SC_RELEASE;
      end else if (roll < 75) begin
         code = 8'($urandom_range(0, 127)) | SC_RELEASE;
      end else if (roll < 83) begin
         code = roll[0] ? SC_LSHIFT : SC_RSHIFT;
         if (roll < 79) code = code | SC_RELEASE;
      end else if (roll < 86) begin
         code = SC_CAPS;
      end else begin
         code = 8'($urandom_range(0, 255));
      end
      return code;
   endfunction

   // Called at a falling edge; returns at the falling edge after the
   // transfer. Valid is only lowered when a gap is inserted, so it never
   // falls and rises within one time step.
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(negedge clock);
      while (ring_model.pending() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int read_pct);
      req_type item;
      repeat (count) begin
         if ($urandom_range(0, 99) < read_pct) begin
            item.cmd       = CMD_READ;
            item.scan_byte = 8'($urandom_range(0, 255));
         end else begin
            item.cmd       = CMD_SCAN;
            item.scan_byte = pick_scan();
         end
         send_item(item);
      end
   endtask

   // A read of the empty ring, a key with no character, plain, shifted
   // and caps-locked keys, both shift keys pressed and released, a caps
   // lock release that must be ignored, the last table entry, codes past
   // the table, the extreme byte values, and reads of part of what was typed.
   task automatic run_directed();
      req_type script [24];
      script = '{
         {CMD_READ, 8'hFF}, {CMD_SCAN, 8'h00}, {CMD_SCAN, 8'h10}, {CMD_SCAN, 8'h2A},
         {CMD_SCAN, 8'h10}, {CMD_SCAN, 8'hAA}, {CMD_SCAN, 8'h36}, {CMD_SCAN, 8'h02},
         {CMD_SCAN, 8'hB6}, {CMD_SCAN, 8'h3A}, {CMD_SCAN, 8'hBA}, {CMD_SCAN, 8'h1E},
         {CMD_SCAN, 8'h3A}, {CMD_SCAN, 8'h39}, {CMD_SCAN, 8'h37}, {CMD_SCAN, 8'h38},
         {CMD_SCAN, 8'h3B}, {CMD_SCAN, 8'h7F}, {CMD_SCAN, 8'h80}, {CMD_SCAN, 8'hFF},
         {CMD_SCAN, 8'h01}, {CMD_READ, 8'h00}, {CMD_READ, 8'h5A}, {CMD_READ, 8'hFF}};
      foreach (script[i]) send_item(script[i]);
   endtask

   initial begin
      ring_model = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      // A long write-heavy phase overruns the ring so that characters are
      // dropped, then a read-heavy phase empties it again and keeps reading
      // the empty ring, and a balanced phase mixes both at partial fill.
      drain_wait();
      run_phase(700, 5);
      drain_wait();
      run_phase(400, 85);
      drain_wait();
      run_phase(200, 50);

      req_valid <= 1'b0;
      while (ring_model.pending() != 0) @(negedge clock);
      // Anything that leaves the block now is a stray response.
      repeat (20) @(negedge clock);
      if (ring_model.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hang, such as a response that never comes.
   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("ERROR: cycle limit reached with %0d responses outstanding",
               ring_model.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
design/scta_pkg.sv
design/scta_ram.sv
design/scta_translate.sv
design/scancode_to_ascii_fifo_core.sv
sim/scancode_to_ascii_fifo_core_tb.sv
